FILE: rtl/rgb_led_chain_serializer_core_macros.svh
// Assertion macros used by the checker file.
`ifndef RGB_LED_CHAIN_SERIALIZER_CORE_MACROS_SVH
`define RGB_LED_CHAIN_SERIALIZER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RLCS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RLCS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rlcs_pkg.sv
// Types, codes and reset constants of the LED chain serializer.
`default_nettype none

package rlcs_pkg;

	localparam int RLCS_MAX_LEDS = 256;
	localparam int BITS_PER_PIXEL = 24;

	localparam logic [1:0] MODE_PIXEL   = 2'd0;
	localparam logic [1:0] MODE_FILL    = 2'd1;
	localparam logic [1:0] MODE_REFRESH = 2'd2;
	localparam logic [1:0] MODE_TICK    = 2'd3;

	localparam logic [2:0] REG_LED_COUNT  = 3'd0;
	localparam logic [2:0] REG_ZERO_HIGH  = 3'd1;
	localparam logic [2:0] REG_ZERO_LOW   = 3'd2;
	localparam logic [2:0] REG_ONE_HIGH   = 3'd3;
	localparam logic [2:0] REG_ONE_LOW    = 3'd4;
	localparam logic [2:0] REG_RESET_LEN  = 3'd5;

	localparam logic [8:0]  RST_LED_COUNT = 9'd0;
	localparam logic [15:0] RST_ZERO_HIGH = 16'd1;
	localparam logic [15:0] RST_ZERO_LOW  = 16'd5;
	localparam logic [15:0] RST_ONE_HIGH  = 16'd5;
	localparam logic [15:0] RST_ONE_LOW   = 16'd1;
	localparam logic [15:0] RST_RESET_LEN = 16'd1500;

	typedef struct packed {
		logic [8:0]  led_count;
		logic [15:0] zero_high_ticks;
		logic [15:0] zero_low_ticks;
		logic [15:0] one_high_ticks;
		logic [15:0] one_low_ticks;
		logic [15:0] reset_len;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic fill_start;
		logic sweep_we;
		logic sweep_clear;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic sweep_done;
	} stat_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_SETTLE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_PRE,
		PH_DATA,
		PH_POST
	} phase_t;

endpackage

`default_nettype wire

FILE: rtl/rlcs_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module rlcs_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [4:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	output rlcs_pkg::cfg_t    cfg
);
	import rlcs_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.led_count       <= RST_LED_COUNT;
			cfg_q.zero_high_ticks <= RST_ZERO_HIGH;
			cfg_q.zero_low_ticks  <= RST_ZERO_LOW;
			cfg_q.one_high_ticks  <= RST_ONE_HIGH;
			cfg_q.one_low_ticks   <= RST_ONE_LOW;
			cfg_q.reset_len       <= RST_RESET_LEN;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LED_COUNT: cfg_q.led_count       <= pwdata[8:0];
				REG_ZERO_HIGH: cfg_q.zero_high_ticks <= pwdata[15:0];
				REG_ZERO_LOW:  cfg_q.zero_low_ticks  <= pwdata[15:0];
				REG_ONE_HIGH:  cfg_q.one_high_ticks  <= pwdata[15:0];
				REG_ONE_LOW:   cfg_q.one_low_ticks   <= pwdata[15:0];
				REG_RESET_LEN: cfg_q.reset_len       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LED_COUNT: prdata = 32'(cfg_q.led_count);
			REG_ZERO_HIGH: prdata = 32'(cfg_q.zero_high_ticks);
			REG_ZERO_LOW:  prdata = 32'(cfg_q.zero_low_ticks);
			REG_ONE_HIGH:  prdata = 32'(cfg_q.one_high_ticks);
			REG_ONE_LOW:   prdata = 32'(cfg_q.one_low_ticks);
			REG_RESET_LEN: prdata = 32'(cfg_q.reset_len);
			default:       prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/rlcs_ctrl.sv
// Request controller: store clearing, fill sweep and result handshake.
`default_nettype none

module rlcs_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   in_mode,
	output logic              out_valid,
	input  wire logic         out_ready,
	input  wire rlcs_pkg::stat_t stat,
	output rlcs_pkg::cmd_t    cmd
);
	import rlcs_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_n;
	logic        out_valid_q;
	logic        accept;
	logic        fill_go;

	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign fill_go   = accept && (in_mode == MODE_FILL) && !stat.busy;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR:  if (stat.sweep_done) state_n = ST_IDLE;
			ST_IDLE:   if (fill_go) state_n = ST_FILL;
			ST_FILL:   if (stat.sweep_done) state_n = ST_SETTLE;
			ST_SETTLE: state_n = ST_IDLE;
			default:   state_n = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd.accept      = accept;
		cmd.fill_start  = fill_go;
		cmd.sweep_we    = ((state_q == ST_CLEAR) || (state_q == ST_FILL)) && !stat.sweep_done;
		cmd.sweep_clear = (state_q == ST_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= (out_valid_q && !out_ready) || (accept && !fill_go)
				|| (state_q == ST_SETTLE);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/rlcs_dp.sv
// Datapath: pixel store, sweep counter, waveform state and result register.
`default_nettype none

module rlcs_dp #(
	parameter int MAX_LEDS = rlcs_pkg::RLCS_MAX_LEDS
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire rlcs_pkg::cfg_t cfg,
	input  wire rlcs_pkg::cmd_t cmd,
	input  wire logic [1:0]   in_mode,
	input  wire logic [7:0]   in_index,
	input  wire logic [23:0]  in_color,
	output rlcs_pkg::stat_t   stat,
	output logic              out_pin,
	output logic              out_busy
);
	import rlcs_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int CW = $clog2(MAX_LEDS + 1);
	localparam int LW = (CW > 9) ? CW : 9;
	localparam logic [LW-1:0] MAX_W = LW'(MAX_LEDS);

	logic [23:0]   mem [MAX_LEDS];
	logic [23:0]   rd_data_q;
	logic [AW-1:0] nxt_idx_q, nxt_idx_n;
	logic [CW-1:0] cnt_q;
	logic [23:0]   color_q;
	logic          out_pin_q, out_busy_q;

	phase_t        phase_q, phase_n;
	logic [8:0]    pix_q, pix_n;
	logic [4:0]    bit_q, bit_n;
	logic [15:0]   tick_q, tick_n;
	logic [23:0]   shift_q, shift_n;
	logic          high_q, high_n;

	logic          busy;
	logic          level;
	logic [LW-1:0] lc_w, act_w;
	logic [8:0]    act;
	logic [CW-1:0] target;
	logic [15:0]   seg_len, tick_inc;
	logic          seg_end;
	logic [4:0]    bit_inc;
	logic [8:0]    pix_inc;
	logic          do_tick, do_start, do_pixel;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [23:0]   wr_data;

	assign busy     = (phase_q != PH_IDLE);
	assign level    = (phase_q == PH_DATA) && high_q;
	assign lc_w     = LW'(cfg.led_count);
	assign act_w    = (lc_w > MAX_W) ? MAX_W : lc_w;
	assign act      = 9'(act_w);
	assign target   = cmd.sweep_clear ? CW'(MAX_LEDS) : CW'(act_w);
	assign tick_inc = tick_q + 16'd1;
	assign bit_inc  = bit_q + 5'd1;
	assign pix_inc  = pix_q + 9'd1;

	assign stat.busy       = busy;
	assign stat.sweep_done = (cnt_q >= target);

	assign do_tick  = cmd.accept && busy && (in_mode == MODE_TICK);
	assign do_start = cmd.accept && !busy
		&& ((in_mode == MODE_FILL) || (in_mode == MODE_REFRESH));
	assign do_pixel = cmd.accept && !busy && (in_mode == MODE_PIXEL)
		&& (LW'(in_index) < MAX_W);

	always_comb begin
		if (phase_q != PH_DATA) begin
			seg_len = cfg.reset_len;
		end else if (high_q) begin
			seg_len = shift_q[23] ? cfg.one_high_ticks : cfg.zero_high_ticks;
		end else begin
			seg_len = shift_q[23] ? cfg.one_low_ticks : cfg.zero_low_ticks;
		end
	end

	assign seg_end = (tick_inc >= seg_len);

	always_comb begin
		phase_n   = phase_q;
		pix_n     = pix_q;
		bit_n     = bit_q;
		tick_n    = tick_q;
		shift_n   = shift_q;
		high_n    = high_q;
		nxt_idx_n = nxt_idx_q;
		if (do_tick) begin
			tick_n = seg_end ? 16'd0 : tick_inc;
			if (seg_end) begin
				unique case (phase_q)
					PH_PRE: begin
						if (act == 9'd0) begin
							phase_n = PH_POST;
						end else begin
							phase_n   = PH_DATA;
							pix_n     = 9'd0;
							shift_n   = rd_data_q;
							bit_n     = 5'd0;
							high_n    = 1'b1;
							nxt_idx_n = AW'(9'd1);
						end
					end
					PH_DATA: begin
						if (high_q) begin
							high_n = 1'b0;
						end else begin
							bit_n   = bit_inc;
							shift_n = {shift_q[22:0], 1'b0};
							high_n  = 1'b1;
							if (bit_inc >= 5'(BITS_PER_PIXEL)) begin
								pix_n = pix_inc;
								if (pix_inc >= act) begin
									phase_n   = PH_POST;
									high_n    = 1'b0;
									bit_n     = 5'd0;
									nxt_idx_n = '0;
								end else begin
									shift_n   = rd_data_q;
									bit_n     = 5'd0;
									nxt_idx_n = AW'(pix_inc + 9'd1);
								end
							end
						end
					end
					PH_POST: begin
						phase_n   = PH_IDLE;
						pix_n     = 9'd0;
						bit_n     = 5'd0;
						shift_n   = 24'd0;
						high_n    = 1'b0;
						nxt_idx_n = '0;
					end
					default: phase_n = PH_IDLE;
				endcase
			end
		end else if (do_start) begin
			phase_n = PH_PRE;
			tick_n  = 16'd0;
			pix_n   = 9'd0;
			bit_n   = 5'd0;
			shift_n = 24'd0;
			high_n  = 1'b0;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(cnt_q);
		wr_data = cmd.sweep_clear ? 24'd0 : color_q;
		if (cmd.sweep_we) begin
			wr_en = 1'b1;
		end else if (do_pixel) begin
			wr_en   = 1'b1;
			wr_addr = AW'(in_index);
			wr_data = in_color;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[nxt_idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_start) begin
			color_q <= in_color;
		end
		if (cmd.accept) begin
			out_pin_q  <= level;
			out_busy_q <= busy || (in_mode == MODE_FILL) || (in_mode == MODE_REFRESH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			pix_q     <= 9'd0;
			bit_q     <= 5'd0;
			tick_q    <= 16'd0;
			shift_q   <= 24'd0;
			high_q    <= 1'b0;
			nxt_idx_q <= '0;
			cnt_q     <= '0;
		end else begin
			phase_q   <= phase_n;
			pix_q     <= pix_n;
			bit_q     <= bit_n;
			tick_q    <= tick_n;
			shift_q   <= shift_n;
			high_q    <= high_n;
			nxt_idx_q <= nxt_idx_n;
			if (cmd.fill_start) begin
				cnt_q <= '0;
			end else if (cmd.sweep_we) begin
				cnt_q <= cnt_q + CW'(1);
			end
		end
	end

	assign out_pin  = out_pin_q;
	assign out_busy = out_busy_q;

endmodule

`default_nettype wire

FILE: rtl/rgb_led_chain_serializer_core.sv
// Top level of the single-wire RGB LED chain serializer.
// After reset the block clears its MAX_LEDS-entry pixel store, one entry per cycle, and accepts
// no request until the clear is done (register writes are taken at any time). Afterwards a
// tick, a pixel write or a refresh request is accepted and its result is registered for
// the next cycle; requests can follow in every cycle while results are taken.
// A write-all request (mode 1, when no refresh is running) writes the first n store entries
// through its single write port one pixel per cycle, n being led_count capped at MAX_LEDS,
// and its result is registered after a settle state; no request is taken meanwhile. Each tick
// request advances the line waveform by one tick; pin is the level of the line during that tick.
`default_nettype none

module rgb_led_chain_serializer_core #(
	parameter int MAX_LEDS = rlcs_pkg::RLCS_MAX_LEDS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// led_index[7:0], red[15:8], green[23:16], blue[31:24]
	input  wire logic [31:0] s_axis_tdata,
	// mode[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// pin[0], busy_res[1], zero[7:2]
	output logic [7:0]       m_axis_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import rlcs_pkg::*;

	cfg_t        cfg;
	cmd_t        cmd;
	stat_t       stat;
	logic [23:0] in_color;
	logic        out_pin;
	logic        out_busy;

	assign in_color     = {s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[31:24]};
	assign m_axis_tdata = {6'd0, out_busy, out_pin};

	rlcs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rlcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_mode   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rlcs_dp #(
		.MAX_LEDS (MAX_LEDS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.in_mode  (s_axis_tuser),
		.in_index (s_axis_tdata[7:0]),
		.in_color (in_color),
		.stat     (stat),
		.out_pin  (out_pin),
		.out_busy (out_busy)
	);

endmodule

`default_nettype wire

FILE: rtl/rlcs_checker.sv
// Port-level checker for the serializer, bound to the top level.
`default_nettype none

`include "rgb_led_chain_serializer_core_macros.svh"

module rlcs_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [1:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata
);
	import rlcs_pkg::*;

	`RLCS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
	`RLCS_ASSERT_IMP(a_no_overrun, s_axis_tvalid && s_axis_tready, !m_axis_tvalid || m_axis_tready, "request taken over a pending result")
	`RLCS_ASSERT_NXT(a_tick_result, s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_TICK), m_axis_tvalid, "tick result late")
	`RLCS_ASSERT_IMP(a_idle_low, m_axis_tvalid && !m_axis_tdata[1], !m_axis_tdata[0], "line high while idle")

endmodule

bind rgb_led_chain_serializer_core rlcs_checker u_rlcs_checker (.*);

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench of the LED chain serializer: directed request table and directed cases, then random frames.
`timescale 1ns / 1ps

module tb_top;
	import rlcs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500_000;
	localparam int unsigned RANDOM_TARGET = 400;
	localparam int unsigned IDLE_PCT = 28;
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic busy;
		logic pin;
	} line_result_t;

	localparam line_result_t LINE_QUIET = 2'b00;
	localparam line_result_t LINE_ARMED = 2'b10;

	typedef struct packed {
		logic         drain;
		logic         typed;
		line_result_t want;
		logic [1:0]   mode;
		logic [7:0]   idx;
		logic [7:0]   red;
		logic [7:0]   green;
		logic [7:0]   blue;
	} stim_row_t;

	localparam stim_row_t STIM_ROWS [17] = '{
		'{1'b0, 1'b1, LINE_QUIET, MODE_TICK,    8'd0,   8'h00, 8'h00, 8'h00},
		'{1'b0, 1'b1, LINE_QUIET, MODE_PIXEL,   8'd0,   8'hff, 8'hff, 8'hff},
		'{1'b0, 1'b1, LINE_QUIET, MODE_PIXEL,   8'd255, 8'h00, 8'h00, 8'h00},
		'{1'b0, 1'b1, LINE_QUIET, MODE_PIXEL,   8'd1,   8'ha5, 8'h3c, 8'h0f},
		'{1'b0, 1'b1, LINE_ARMED, MODE_REFRESH, 8'd0,   8'h00, 8'h00, 8'h00},
		'{1'b0, 1'b1, LINE_ARMED, MODE_PIXEL,   8'd2,   8'hff, 8'hff, 8'hff},
		'{1'b0, 1'b1, LINE_ARMED, MODE_REFRESH, 8'd0,   8'h00, 8'h00, 8'h00},
		'{1'b0, 1'b1, LINE_ARMED, MODE_FILL,    8'd0,   8'h12, 8'h34, 8'h56},
		'{1'b0, 1'b1, LINE_ARMED, MODE_TICK,    8'd0,   8'h00, 8'h00, 8'h00},
		'{1'b0, 1'b0, LINE_QUIET, MODE_TICK,    8'hff,  8'hff, 8'hff, 8'hff},
		'{1'b1, 1'b0, LINE_QUIET, MODE_TICK,    8'd0,   8'h00, 8'h00, 8'h00},
		'{1'b0, 1'b1, LINE_QUIET, MODE_TICK,    8'd0,   8'h00, 8'h00, 8'h00},
		'{1'b0, 1'b1, LINE_ARMED, MODE_FILL,    8'd0,   8'h00, 8'hff, 8'h01},
		'{1'b1, 1'b0, LINE_QUIET, MODE_TICK,    8'd0,   8'h00, 8'h00, 8'h00},
		'{1'b0, 1'b1, LINE_QUIET, MODE_PIXEL,   8'd255, 8'hff, 8'hff, 8'hff},
		'{1'b0, 1'b1, LINE_ARMED, MODE_REFRESH, 8'd0,   8'h00, 8'h00, 8'h00},
		'{1'b1, 1'b0, LINE_QUIET, MODE_TICK,    8'd0,   8'h00, 8'h00, 8'h00}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	cfg_t         line_cfg;
	logic [23:0]  color_mem [RLCS_MAX_LEDS];
	phase_t       frame_state;
	logic [8:0]   led_ptr;
	logic [4:0]   bit_ptr;
	logic [15:0]  tick_ctr;
	logic [23:0]  color_shift;
	logic         in_high;
	logic         item_ignored;

	line_result_t line_results [$];
	int unsigned  useful_items;
	int unsigned  fail_count = 0;
	int unsigned  cycle_count = 0;
	bit           calm = 1'b0;
	bit           held_once = 1'b0;

	rgb_led_chain_serializer_core DUT (.*);

	always #6 clk = ~clk;

	function automatic logic [8:0] chain_led_limit();
		return (line_cfg.led_count > 9'(RLCS_MAX_LEDS)) ? 9'(RLCS_MAX_LEDS) : line_cfg.led_count;
	endfunction

	function automatic logic wire_level();
		return (frame_state == PH_DATA) ? in_high : 1'b0;
	endfunction

	function automatic logic [15:0] span_ticks();
		if (frame_state != PH_DATA)
			return line_cfg.reset_len;
		if (in_high)
			return color_shift[23] ? line_cfg.one_high_ticks : line_cfg.zero_high_ticks;
		return color_shift[23] ? line_cfg.one_low_ticks : line_cfg.zero_low_ticks;
	endfunction

	function automatic void fetch_color();
		color_shift = (led_ptr < 9'(RLCS_MAX_LEDS)) ? color_mem[led_ptr[7:0]] : color_mem[0];
		bit_ptr = '0;
		in_high = 1'b1;
	endfunction

	function automatic void advance_span();
		case (frame_state)
			PH_PRE: begin
				if (chain_led_limit() == 9'd0) begin
					frame_state = PH_POST;
				end else begin
					frame_state = PH_DATA;
					led_ptr = '0;
					fetch_color();
				end
			end
			PH_DATA: begin
				if (in_high) begin
					in_high = 1'b0;
				end else begin
					bit_ptr = bit_ptr + 5'd1;
					color_shift = {color_shift[22:0], 1'b0};
					in_high = 1'b1;
					if (bit_ptr >= 5'(BITS_PER_PIXEL)) begin
						led_ptr = led_ptr + 9'd1;
						if (led_ptr >= chain_led_limit()) begin
							frame_state = PH_POST;
							in_high = 1'b0;
							bit_ptr = '0;
						end else begin
							fetch_color();
						end
					end
				end
			end
			default: begin
				frame_state = PH_IDLE;
				led_ptr = '0;
				bit_ptr = '0;
				color_shift = '0;
				in_high = 1'b0;
			end
		endcase
	endfunction

	function automatic line_result_t predict_led_line(logic [1:0] mode, logic [7:0] idx,
			logic [7:0] red, logic [7:0] green, logic [7:0] blue);
		line_result_t res;
		logic         was_busy;
		logic         lvl;
		logic [23:0]  color;
		color = {green, red, blue};
		was_busy = (frame_state != PH_IDLE);
		item_ignored = 1'b0;
		if (mode == MODE_TICK) begin
			lvl = wire_level();
			if (was_busy) begin
				tick_ctr = tick_ctr + 16'd1;
				if (tick_ctr >= span_ticks()) begin
					tick_ctr = '0;
					advance_span();
				end
			end
			res.pin = was_busy & lvl;
			res.busy = was_busy;
		end else begin
			if (was_busy) begin
				item_ignored = 1'b1;
			end else if (mode == MODE_PIXEL) begin
				color_mem[idx] = color;
			end else begin
				if (mode == MODE_FILL)
					for (int k = 0; k < int'(chain_led_limit()); k++)
						color_mem[k] = color;
				frame_state = PH_PRE;
				tick_ctr = '0;
				led_ptr = '0;
				bit_ptr = '0;
				color_shift = '0;
				in_high = 1'b0;
			end
			res.pin = wire_level();
			res.busy = (frame_state != PH_IDLE);
		end
		return res;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_LED_COUNT: line_cfg.led_count = value[8:0];
			REG_ZERO_HIGH: line_cfg.zero_high_ticks = value[15:0];
			REG_ZERO_LOW:  line_cfg.zero_low_ticks = value[15:0];
			REG_ONE_HIGH:  line_cfg.one_high_ticks = value[15:0];
			REG_ONE_LOW:   line_cfg.one_low_ticks = value[15:0];
			REG_RESET_LEN: line_cfg.reset_len = value[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_item(input logic [1:0] mode, input logic [7:0] idx, input logic [7:0] red,
			input logic [7:0] green, input logic [7:0] blue, input bit typed = 1'b0,
			input line_result_t want = LINE_QUIET);
		line_result_t pred;
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = mode;
		s_axis_tdata = {blue, green, red, idx};
		do @(posedge clk); while (!s_axis_tready);
		pred = predict_led_line(mode, idx, red, green, blue);
		line_results.push_back(typed ? want : pred);
		if (!item_ignored)
			useful_items++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (line_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic tick_until_idle();
		int n;
		n = 0;
		while (frame_state != PH_IDLE) begin
			if (!held_once && n == 3) begin
				drain_results();
				held_once = 1'b1;
			end
			send_item(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			n++;
		end
	endtask

	always @(negedge clk)
		m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin : check_line
		line_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (line_results.size() == 0) begin
				$error("result with no request pending: tdata %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = line_results.pop_front();
				if (m_axis_tdata[0] !== want.pin) begin
					$error("pin: expected %b, actual %b", want.pin, m_axis_tdata[0]);
					fail_count++;
				end
				if (m_axis_tdata[1] !== want.busy) begin
					$error("busy_res: expected %b, actual %b", want.busy, m_axis_tdata[1]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t  row;
		int         pick;
		logic [7:0] idx;
		line_cfg.led_count = RST_LED_COUNT;
		line_cfg.zero_high_ticks = RST_ZERO_HIGH;
		line_cfg.zero_low_ticks = RST_ZERO_LOW;
		line_cfg.one_high_ticks = RST_ONE_HIGH;
		line_cfg.one_low_ticks = RST_ONE_LOW;
		line_cfg.reset_len = RST_RESET_LEN;
		for (int k = 0; k < RLCS_MAX_LEDS; k++)
			color_mem[k] = '0;
		frame_state = PH_IDLE;
		led_ptr = '0;
		bit_ptr = '0;
		tick_ctr = '0;
		color_shift = '0;
		in_high = 1'b0;
		item_ignored = 1'b0;
		useful_items = 0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_LED_COUNT, 32'd2);
		write_reg(REG_ZERO_HIGH, 32'd1);
		write_reg(REG_ZERO_LOW, 32'd2);
		write_reg(REG_ONE_HIGH, 32'd2);
		write_reg(REG_ONE_LOW, 32'd1);
		write_reg(REG_RESET_LEN, 32'd2);
		write_reg(REG_SPARE_A, 32'hffff_ffff);
		write_reg(REG_SPARE_B, 32'h0000_0007);

		for (int i = 0; i < $size(STIM_ROWS); i++) begin
			row = STIM_ROWS[i];
			if (row.drain)
				tick_until_idle();
			else
				send_item(row.mode, row.idx, row.red, row.green, row.blue, row.typed, row.want);
		end
		drain_results();

		// empty chain: only the two reset lows
		write_reg(REG_LED_COUNT, 32'd0);
		write_reg(REG_RESET_LEN, 32'd3);
		send_item(MODE_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0);
		tick_until_idle();
		send_item(MODE_FILL, 8'd0, 8'hff, 8'hff, 8'hff);
		tick_until_idle();
		drain_results();

		// zero-length spans
		write_reg(REG_LED_COUNT, 32'd2);
		write_reg(REG_ZERO_HIGH, 32'd0);
		write_reg(REG_ZERO_LOW, 32'd0);
		write_reg(REG_ONE_HIGH, 32'd0);
		write_reg(REG_ONE_LOW, 32'd0);
		write_reg(REG_RESET_LEN, 32'd0);
		send_item(MODE_FILL, 8'd0, 8'($urandom), 8'($urandom), 8'($urandom));
		tick_until_idle();
		drain_results();

		// one pixel, back to back
		calm = 1'b1;
		write_reg(REG_LED_COUNT, 32'd1);
		write_reg(REG_ZERO_HIGH, 32'd1);
		write_reg(REG_ZERO_LOW, 32'd1);
		write_reg(REG_ONE_HIGH, 32'd3);
		write_reg(REG_ONE_LOW, 32'd3);
		write_reg(REG_RESET_LEN, 32'd40);
		send_item(MODE_PIXEL, 8'd0, 8'h00, 8'h80, 8'h00);
		send_item(MODE_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0);
		tick_until_idle();
		drain_results();
		calm = 1'b0;

		useful_items = 0;
		while (useful_items < RANDOM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 10)
				write_reg(REG_LED_COUNT, 32'd0);
			else if (pick < 75)
				write_reg(REG_LED_COUNT, $urandom_range(1, 3));
			else
				write_reg(REG_LED_COUNT, $urandom_range(4, 6));
			write_reg(REG_ZERO_HIGH, $urandom_range(0, 3));
			write_reg(REG_ZERO_LOW, $urandom_range(0, 3));
			write_reg(REG_ONE_HIGH, $urandom_range(0, 3));
			write_reg(REG_ONE_LOW, $urandom_range(0, 3));
			write_reg(REG_RESET_LEN, $urandom_range(0, 4));
			if ($urandom_range(0, 99) < 20) begin
				repeat ($urandom_range(5, 30))
					send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
						8'($urandom), 8'($urandom));
			end else begin
				repeat ($urandom_range(0, 6)) begin
					if (line_cfg.led_count != 9'd0 && $urandom_range(0, 99) < 70)
						idx = 8'($urandom_range(0, int'(line_cfg.led_count) - 1));
					else
						idx = 8'($urandom_range(0, 255));
					send_item(MODE_PIXEL, idx, 8'($urandom), 8'($urandom), 8'($urandom));
				end
				send_item(($urandom_range(0, 99) < 30) ? MODE_FILL : MODE_REFRESH, 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
				while (frame_state != PH_IDLE) begin
					pick = $urandom_range(0, 99);
					if (pick < 8) begin
						send_item(2'($urandom_range(0, 2)), 8'($urandom), 8'($urandom),
							8'($urandom), 8'($urandom));
					end else begin
						if (pick == 99)
							drain_results();
						send_item(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
							8'($urandom));
					end
				end
				repeat ($urandom_range(0, 3))
					send_item(MODE_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			end
			tick_until_idle();
			drain_results();
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
